// ----- sv/assert_macros.svh -----
// assertion macros used by the rtl top level
// expands to nothing when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/utcl_pkg.sv -----
// types and constants of the utf-8 text cursor
// no dependencies
`default_nettype none
package utcl_pkg;

  localparam int BYTE_W    = 8;
  localparam int CODE_W    = 16;
  localparam int OUT_W     = 16;
  localparam int CFG_W     = 16;
  localparam int SCALE_W   = 5;
  localparam int CFG_IDX_W = 3;
  // 20 * 31 fits in ten bits
  localparam int STEP_W    = 10;

  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0a;
  localparam logic [2:0]        LEAD2_TAG    = 3'h6;
  localparam logic [3:0]        LEAD3_TAG    = 4'he;

  localparam logic [CFG_W-1:0]   SCREEN_WIDTH_RST = 16'd1024;
  localparam logic [SCALE_W-1:0] SCALE_RST        = 5'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X     = 3'd0,
    CFG_ORIGIN_Y     = 3'd1,
    CFG_SCALE        = 3'd2,
    CFG_SCREEN_WIDTH = 3'd3
  } utcl_cfg_idx_t;

  typedef enum logic [2:0] {
    KIND_SKIP    = 3'd0,
    KIND_CONT    = 3'd1,
    KIND_LEAD    = 3'd2,
    KIND_ASCII   = 3'd3,
    KIND_NEWLINE = 3'd4,
    KIND_DONE    = 3'd5
  } utcl_kind_t;

  typedef struct packed {
    utcl_kind_t        kind;
    logic [CODE_W-1:0] code;
  } utcl_dec_t;

  typedef struct packed {
    logic [CFG_W-1:0]   origin_x;
    logic [CFG_W-1:0]   origin_y;
    logic [SCALE_W-1:0] scale;
    logic [CFG_W-1:0]   screen_width;
  } utcl_cfg_t;

endpackage
`default_nettype wire

// ----- sv/utcl_if.sv -----
// request channels of the utf-8 text cursor: text bytes in, placed glyphs out
// depends on utcl_pkg
`default_nettype none
interface utcl_in_if;
  logic                          valid;
  logic                          ready;
  logic [utcl_pkg::BYTE_W-1:0]   text_byte;
  logic                          new_text;
  modport source (output valid, output text_byte, output new_text, input ready);
  modport sink   (input valid, input text_byte, input new_text, output ready);
endinterface

interface utcl_out_if;
  logic                          valid;
  logic                          ready;
  logic [utcl_pkg::CODE_W-1:0]   code_point;
  logic [utcl_pkg::OUT_W-1:0]    place_x;
  logic [utcl_pkg::OUT_W-1:0]    place_y;
  logic                          wide;
  modport source (output valid, output code_point, output place_x, output place_y,
                  output wide, input ready);
  modport sink   (input valid, input code_point, input place_x, input place_y,
                  input wide, output ready);
endinterface
`default_nettype wire

// ----- sv/utf8_text_cursor_layout.sv -----
// top level of the utf-8 text cursor: registers, byte stage, result stage
// depends on utcl_pkg, utcl_if, utcl_decode, utcl_cursor, assert_macros.svh
//
//   port     dir   what travels
//   in_ch    sink  text_byte, new_text
//   out_ch   src   code_point, place_x, place_y, wide
//   cfg_*    in    register write: index, data
//
// one byte per cycle sustained unless out_ch stalls; a result shows after its last
// byte is taken, through the byte register, then the result register
// the cursor state loop closes through decode and a saturating add
// rst_n is synchronous; it clears the cursor, pending code and both stages
// with out_ch stalled and both stages full, in_ch.ready drops
`default_nettype none
`include "assert_macros.svh"
module utf8_text_cursor_layout #(
  parameter int COORD_WIDTH = 16
) (
  input  wire                              clk,
  input  wire                              rst_n,
  utcl_in_if.sink                          in_ch,
  utcl_out_if.source                       out_ch,
  input  wire                              cfg_wr_en,
  input  wire [utcl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [utcl_pkg::CFG_W-1:0]        cfg_wdata
);

  utcl_pkg::utcl_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x     <= '0;
      cfg_r.origin_y     <= '0;
      cfg_r.scale        <= utcl_pkg::SCALE_RST;
      cfg_r.screen_width <= utcl_pkg::SCREEN_WIDTH_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        utcl_pkg::CFG_ORIGIN_X:     cfg_r.origin_x     <= cfg_wdata;
        utcl_pkg::CFG_ORIGIN_Y:     cfg_r.origin_y     <= cfg_wdata;
        utcl_pkg::CFG_SCALE:        cfg_r.scale        <= cfg_wdata[utcl_pkg::SCALE_W-1:0];
        utcl_pkg::CFG_SCREEN_WIDTH: cfg_r.screen_width <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // byte stage
  logic                        s1_valid_r;
  logic [utcl_pkg::BYTE_W-1:0] s1_byte_r;
  logic                        s1_new_text_r;
  logic                        s1_adv;
  logic                        out_valid_r;

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r     <= in_ch.text_byte;
      s1_new_text_r <= in_ch.new_text;
    end
  end

  utcl_pkg::utcl_dec_t     dec;
  logic [COORD_WIDTH-1:0]  place_x, place_y;
  logic                    res_valid;

  utcl_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (s1_adv),
    .text_byte (s1_byte_r),
    .new_text  (s1_new_text_r),
    .dec       (dec)
  );

  utcl_cursor #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_cursor (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (s1_adv),
    .new_text (s1_new_text_r),
    .kind     (dec.kind),
    .cfg      (cfg_r),
    .place_x  (place_x),
    .place_y  (place_y)
  );

  assign res_valid = (dec.kind == utcl_pkg::KIND_ASCII) || (dec.kind == utcl_pkg::KIND_DONE);

  // result stage
  logic [utcl_pkg::CODE_W-1:0] code_r;
  logic [utcl_pkg::OUT_W-1:0]  place_x_r, place_y_r;
  logic                        wide_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= res_valid;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_valid) begin
      code_r    <= dec.code;
      place_x_r <= utcl_pkg::OUT_W'(place_x);
      place_y_r <= utcl_pkg::OUT_W'(place_y);
      wide_r    <= (dec.kind == utcl_pkg::KIND_DONE);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.code_point = code_r;
  assign out_ch.place_x    = place_x_r;
  assign out_ch.place_y    = place_y_r;
  assign out_ch.wide       = wide_r;

  // a one-byte result is never zero, a newline or above seven bits
  `ASSERT_IMPLY(a_narrow_code, clk, rst_n, out_valid_r && !wide_r, (code_r[15:7] == '0) && (code_r != '0) && (code_r != 16'(utcl_pkg::NEWLINE_BYTE)))
  // a new result only comes from a byte leaving the byte stage
  `ASSERT_IMPLY(a_result_source, clk, rst_n, $rose(out_valid_r), $past(s1_adv))
  // a plain character always gives a narrow result
  `ASSERT_NEXT(a_ascii_result, clk, rst_n, s1_adv && (dec.kind == utcl_pkg::KIND_ASCII), out_valid_r && !wide_r)

endmodule
`default_nettype wire

// ----- sv/utcl_decode.sv -----
// utf-8 byte classifier with the pending partial code and byte count
// depends on utcl_pkg
`default_nettype none
module utcl_decode (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          en,
  input  wire [utcl_pkg::BYTE_W-1:0]   text_byte,
  input  wire                          new_text,
  output utcl_pkg::utcl_dec_t          dec
);

  logic [utcl_pkg::CODE_W-1:0] partial_r, partial_nxt, partial_eff;
  logic [1:0]                  left_r, left_nxt, left_eff;

  always_comb begin
    partial_eff = new_text ? '0 : partial_r;
    left_eff    = new_text ? 2'd0 : left_r;
    partial_nxt = partial_eff;
    left_nxt    = left_eff;
    dec.kind    = utcl_pkg::KIND_SKIP;
    dec.code    = utcl_pkg::CODE_W'(text_byte);
    if (left_eff != 2'd0) begin
      // continuation taken without checking its tag
      partial_nxt = {partial_eff[utcl_pkg::CODE_W-7:0], text_byte[5:0]};
      left_nxt    = left_eff - 2'd1;
      dec.kind    = (left_nxt == 2'd0) ? utcl_pkg::KIND_DONE : utcl_pkg::KIND_CONT;
      dec.code    = partial_nxt;
    end else if (text_byte == '0) begin
      dec.kind = utcl_pkg::KIND_SKIP;
    end else if (!text_byte[7]) begin
      dec.kind = (text_byte == utcl_pkg::NEWLINE_BYTE) ? utcl_pkg::KIND_NEWLINE
                                                       : utcl_pkg::KIND_ASCII;
    end else if (text_byte[7:5] == utcl_pkg::LEAD2_TAG) begin
      dec.kind    = utcl_pkg::KIND_LEAD;
      partial_nxt = utcl_pkg::CODE_W'(text_byte[4:0]);
      left_nxt    = 2'd1;
    end else if (text_byte[7:4] == utcl_pkg::LEAD3_TAG) begin
      dec.kind    = utcl_pkg::KIND_LEAD;
      partial_nxt = utcl_pkg::CODE_W'(text_byte[3:0]);
      left_nxt    = 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      left_r    <= 2'd0;
    end else if (en) begin
      partial_r <= partial_nxt;
      left_r    <= left_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/utcl_cursor.sv -----
// drawing cursor: line wrap, newline, advance and glyph anchor
// depends on utcl_pkg
`default_nettype none
module utcl_cursor #(
  parameter int COORD_WIDTH = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          en,
  input  wire                          new_text,
  input  utcl_pkg::utcl_kind_t         kind,
  input  utcl_pkg::utcl_cfg_t          cfg,
  output logic [COORD_WIDTH-1:0]       place_x,
  output logic [COORD_WIDTH-1:0]       place_y
);

  localparam int CW    = COORD_WIDTH;
  localparam int CMP_W = (CW + 1 > utcl_pkg::CFG_W + 1) ? CW + 1 : utcl_pkg::CFG_W + 1;

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a,
                                             input logic [utcl_pkg::STEP_W-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + (CW+1)'(b);
    return s[CW] ? {CW{1'b1}} : s[CW-1:0];
  endfunction

  logic [CW-1:0] cursor_x_r, cursor_x_nxt;
  logic [CW-1:0] cursor_y_r, cursor_y_nxt;
  logic [CW-1:0] glyph_x_r, glyph_x_nxt;
  logic [CW-1:0] glyph_y_r, glyph_y_nxt;

  logic [utcl_pkg::STEP_W-1:0] step8, step16, step20;
  logic [CW-1:0]               org_x, org_y, cx0, cy0, cx1, cy1;
  logic [CMP_W-1:0]            wrap_sum;
  logic                        wrap;

  assign step8  = utcl_pkg::STEP_W'({cfg.scale, 3'b000});
  assign step16 = utcl_pkg::STEP_W'({cfg.scale, 4'b0000});
  assign step20 = step16 + utcl_pkg::STEP_W'({cfg.scale, 2'b00});
  assign org_x  = CW'(cfg.origin_x);
  assign org_y  = CW'(cfg.origin_y);

  always_comb begin
    cx0 = new_text ? org_x : cursor_x_r;
    cy0 = new_text ? org_y : cursor_y_r;
    // wrap compare on the unsaturated sum
    wrap_sum = CMP_W'(cx0) + CMP_W'(step20);
    wrap = ((kind == utcl_pkg::KIND_ASCII) || (kind == utcl_pkg::KIND_NEWLINE) ||
            (kind == utcl_pkg::KIND_LEAD)) && (wrap_sum >= CMP_W'(cfg.screen_width));
    cx1 = wrap ? org_x : cx0;
    cy1 = wrap ? sat_add(cy0, step20) : cy0;

    cursor_x_nxt = cx0;
    cursor_y_nxt = cy0;
    glyph_x_nxt  = glyph_x_r;
    glyph_y_nxt  = glyph_y_r;
    place_x      = cx1;
    place_y      = cy1;
    case (kind)
      utcl_pkg::KIND_ASCII: begin
        cursor_x_nxt = sat_add(cx1, step8);
        cursor_y_nxt = cy1;
      end
      utcl_pkg::KIND_NEWLINE: begin
        // a newline at a full line steps down twice
        cursor_x_nxt = org_x;
        cursor_y_nxt = sat_add(cy1, step20);
      end
      utcl_pkg::KIND_LEAD: begin
        cursor_x_nxt = cx1;
        cursor_y_nxt = cy1;
        glyph_x_nxt  = cx1;
        glyph_y_nxt  = cy1;
      end
      utcl_pkg::KIND_DONE: begin
        place_x      = glyph_x_r;
        place_y      = glyph_y_r;
        cursor_x_nxt = sat_add(glyph_x_r, step16);
      end
      default: begin
        cursor_x_nxt = cx0;
        cursor_y_nxt = cy0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r <= '0;
      cursor_y_r <= '0;
      glyph_x_r  <= '0;
      glyph_y_r  <= '0;
    end else if (en) begin
      cursor_x_r <= cursor_x_nxt;
      cursor_y_r <= cursor_y_nxt;
      glyph_x_r  <= glyph_x_nxt;
      glyph_y_r  <= glyph_y_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sim/utf8_text_cursor_layout_tb.sv -----
`timescale 1ns / 100ps
// testbench of utf8_text_cursor_layout: utf-8 byte requests in, placed glyphs out,
// checked field by field against a cursor predictor kept here
// depends on utcl_pkg, utcl_if and the rtl of the block
module utf8_text_cursor_layout_tb;

  localparam int unsigned LINE_ADV   = 20;
  localparam int unsigned NARROW_ADV = 8;
  localparam int unsigned WIDE_ADV   = 16;
  localparam int unsigned COORD_MAX  = 65535;
  localparam logic [utcl_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_LIMIT    = 4000;
  localparam int LONG_HOLD     = 200;
  localparam int PHASE_ITEMS   = 105;

  typedef struct {
    logic [utcl_pkg::BYTE_W-1:0] text_byte;
    logic                        new_text;
  } text_req_t;

  typedef struct {
    logic [utcl_pkg::CODE_W-1:0] code;
    logic [utcl_pkg::OUT_W-1:0]  x;
    logic [utcl_pkg::OUT_W-1:0]  y;
    logic                        wide;
  } glyph_t;

  logic clk;
  logic rst_n;
  logic                           cfg_wr_en;
  logic [utcl_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [utcl_pkg::CFG_W-1:0]     cfg_wdata;

  utcl_in_if  text_ch ();
  utcl_out_if glyph_ch ();

  utf8_text_cursor_layout uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (text_ch),
    .out_ch    (glyph_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  text_req_t pending_bytes[$];
  glyph_t    glyphs_due[$];

  // predictor state and its copy of the registers
  logic [15:0] org_x, org_y, scr_w;
  logic [4:0]  font_scale;
  logic [15:0] cur_x, cur_y, pend_code, lead_x, lead_y;
  int unsigned pend_left;

  bit in_fired;
  bit gaps_on;
  bit sender_hold;
  bit long_hold_go;
  bit long_hold_seen;
  int send_gap;
  int recv_gap;
  int long_hold_cnt;
  int idle_cycles;
  int errors;
  int text_items;
  int bytes_taken;
  int glyphs_seen;
  int wide_seen;
  int setups_run;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function logic [15:0] clip_coord(input int unsigned s);
    return (s > COORD_MAX) ? 16'(COORD_MAX) : 16'(s);
  endfunction

  function void line_feed();
    cur_x = org_x;
    cur_y = clip_coord(cur_y + LINE_ADV * font_scale);
  endfunction

  // wrap compare is on the unclipped sum
  function void wrap_if_full();
    int unsigned reach;
    reach = cur_x + LINE_ADV * font_scale;
    if (reach >= scr_w) line_feed();
  endfunction

  // one byte through the cursor; returns 1 when a glyph is placed
  function bit place_byte(input logic [7:0] b, input logic nt, output glyph_t g);
    g = '{default: '0};
    if (nt) begin
      cur_x = org_x;
      cur_y = org_y;
      pend_code = '0;
      pend_left = 0;
    end
    if (pend_left != 0) begin
      // continuation taken without looking at the top bits
      pend_code = {pend_code[9:0], b[5:0]};
      pend_left--;
      if (pend_left != 0) return 1'b0;
      cur_x = clip_coord(lead_x + WIDE_ADV * font_scale);
      g = '{pend_code, lead_x, lead_y, 1'b1};
      return 1'b1;
    end
    if (b == 8'h00) return 1'b0;
    if (!b[7]) begin
      wrap_if_full();
      if (b == utcl_pkg::NEWLINE_BYTE) begin
        line_feed();
        return 1'b0;
      end
      g = '{{8'h00, b}, cur_x, cur_y, 1'b0};
      cur_x = clip_coord(cur_x + NARROW_ADV * font_scale);
      return 1'b1;
    end
    if (b[7:5] == utcl_pkg::LEAD2_TAG) begin
      wrap_if_full();
      pend_code = {11'd0, b[4:0]};
      pend_left = 1;
    end else if (b[7:4] == utcl_pkg::LEAD3_TAG) begin
      wrap_if_full();
      pend_code = {12'd0, b[3:0]};
      pend_left = 2;
    end else begin
      return 1'b0;
    end
    lead_x = cur_x;
    lead_y = cur_y;
    return 1'b0;
  endfunction

  function void check_field(input string what, input logic [15:0] want,
                            input logic [15:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= 200)
        $display("%0t: %s expected %h actual %h", $time, what, want, got);
    end
  endfunction

  // sender: holds a request until taken, gaps only between requests
  always @(negedge clk) begin
    text_req_t nxt;
    logic v;
    if (!rst_n) begin
      text_ch.valid <= 1'b0;
    end else begin
      v = text_ch.valid && !in_fired;
      if (!v) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (pending_bytes.size() != 0 && !sender_hold) begin
          if (gaps_on && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 11) - 1;
          end else begin
            nxt = pending_bytes.pop_front();
            text_ch.text_byte <= nxt.text_byte;
            text_ch.new_text  <= nxt.new_text;
            v = 1'b1;
          end
        end
      end
      text_ch.valid <= v;
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    logic r;
    if (!rst_n) begin
      glyph_ch.ready <= 1'b0;
    end else begin
      r = 1'b1;
      if (long_hold_go && !long_hold_seen) begin
        long_hold_seen = 1'b1;
        long_hold_cnt = LONG_HOLD;
      end
      if (long_hold_cnt != 0) begin
        long_hold_cnt--;
        r = 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap--;
        r = 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(1, 11) - 1;
        r = 1'b0;
      end
      glyph_ch.ready <= r;
    end
  end

  // results are checked before the request of the same edge is predicted
  always @(posedge clk) begin
    glyph_t got, want, g;
    bit in_ok, out_ok;
    in_ok  = rst_n && text_ch.valid && text_ch.ready;
    out_ok = rst_n && glyph_ch.valid && glyph_ch.ready;
    in_fired <= in_ok;
    if (out_ok) begin
      got = '{glyph_ch.code_point, glyph_ch.place_x, glyph_ch.place_y, glyph_ch.wide};
      glyphs_seen++;
      if (got.wide) wide_seen++;
      if (glyphs_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected glyph, expected none actual code %h x %h y %h wide %b",
                 $time, got.code, got.x, got.y, got.wide);
      end else begin
        want = glyphs_due.pop_front();
        check_field("code_point", want.code, got.code);
        check_field("place_x", want.x, got.x);
        check_field("place_y", want.y, got.y);
        check_field("wide", {15'd0, want.wide}, {15'd0, got.wide});
      end
    end
    if (in_ok) begin
      bytes_taken++;
      if (place_byte(text_ch.text_byte, text_ch.new_text, g)) glyphs_due.push_back(g);
    end
    idle_cycles = (in_ok || out_ok) ? 0 : idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, IDLE_LIMIT);
      $display("utf8_text_cursor_layout: mismatch");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic nt, input bit counts);
    pending_bytes.push_back('{b, nt});
    if (counts) text_items++;
  endtask

  // mostly well-formed text, some broken sequences and raw noise
  task automatic fill_text(input int n);
    int stop, kind;
    logic nt;
    stop = text_items + n;
    while (text_items < stop) begin
      kind = $urandom_range(0, 99);
      nt = ($urandom_range(0, 24) == 0);
      if (kind < 45) begin
        push_byte(8'($urandom_range(1, 127)), nt, 1);
      end else if (kind < 55) begin
        push_byte(utcl_pkg::NEWLINE_BYTE, nt, 1);
      end else if (kind < 70) begin
        push_byte({utcl_pkg::LEAD2_TAG, 5'($urandom_range(0, 31))}, nt, 1);
        push_byte({2'b10, 6'($urandom_range(0, 63))}, 1'b0, 1);
      end else if (kind < 85) begin
        push_byte({utcl_pkg::LEAD3_TAG, 4'($urandom_range(0, 15))}, nt, 1);
        push_byte({2'b10, 6'($urandom_range(0, 63))}, 1'b0, 1);
        push_byte({2'b10, 6'($urandom_range(0, 63))}, 1'b0, 1);
      end else if (kind < 92) begin
        // lead cut short by a new text or followed by any byte at all
        push_byte({utcl_pkg::LEAD3_TAG, 4'($urandom_range(0, 15))}, nt, 1);
        push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1);
      end else begin
        push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1);
      end
    end
  endtask

  task automatic write_reg(input logic [utcl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [utcl_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      utcl_pkg::CFG_ORIGIN_X:     org_x = val;
      utcl_pkg::CFG_ORIGIN_Y:     org_y = val;
      utcl_pkg::CFG_SCALE:        font_scale = val[4:0];
      utcl_pkg::CFG_SCREEN_WIDTH: scr_w = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // block is idle once nothing is queued, offered or due; then wait SETTLE_CYCLES more
  task automatic settle();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || text_ch.valid || glyphs_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input logic [15:0] ox, input logic [15:0] oy,
                           input logic [4:0] sc, input logic [15:0] sw, input int n);
    settle();
    write_reg(utcl_pkg::CFG_ORIGIN_X, ox);
    write_reg(utcl_pkg::CFG_ORIGIN_Y, oy);
    write_reg(utcl_pkg::CFG_SCALE, {11'd0, sc});
    write_reg(utcl_pkg::CFG_SCREEN_WIDTH, sw);
    setups_run++;
    // start each setting from its origin
    push_byte(8'h20, 1'b1, 1);
    fill_text(n);
  endtask

  initial begin
    bit [8:0] opening_text[$];
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    text_ch.valid = 1'b0;
    text_ch.text_byte = '0;
    text_ch.new_text = 1'b0;
    glyph_ch.ready = 1'b0;
    gaps_on = 1'b1;
    org_x = '0;
    org_y = '0;
    font_scale = utcl_pkg::SCALE_RST;
    scr_w = utcl_pkg::SCREEN_WIDTH_RST;
    cur_x = '0;
    cur_y = '0;
    pend_code = '0;
    pend_left = 0;
    lead_x = '0;
    lead_y = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed text under reset settings: {new_text, byte}
    opening_text = '{9'h141, 9'h07f, 9'h001, 9'h00a, 9'h000, 9'h080, 9'h0bf,
                     9'h0f0, 9'h0ff, 9'h0c3, 9'h0a9, 9'h0df, 9'h0bf,
                     9'h0e2, 9'h082, 9'h0ac, 9'h0ef, 9'h0bf, 9'h0bf,
                     9'h0e0, 9'h000, 9'h041, 9'h0c0, 9'h08a, 9'h0c3, 9'h141};
    foreach (opening_text[i]) push_byte(opening_text[i][7:0], opening_text[i][8], 1);

    run_phase(16'd0, 16'd0, 5'd1, 16'd1024, PHASE_ITEMS);
    settle();
    write_reg(CFG_NO_REG, 16'hffff);
    fill_text(20);
    run_phase(16'd100, 16'd50, 5'd2, 16'd400, PHASE_ITEMS);
    long_hold_go = 1'b1;
    run_phase(16'd0, 16'd0, 5'd16, 16'hffff, PHASE_ITEMS);
    // origin at the far corner: every glyph wraps and both coordinates clip
    run_phase(16'hffff, 16'd65000, 5'd31, 16'hffff, PHASE_ITEMS);
    while (pending_bytes.size() > PHASE_ITEMS / 2) @(negedge clk);
    sender_hold = 1'b1;
    do @(negedge clk); while (text_ch.valid || glyphs_due.size() != 0);
    sender_hold = 1'b0;
    // zero scale: no advance, no line step
    run_phase(16'd10, 16'd0, 5'd0, 16'd1, PHASE_ITEMS);
    // zero width: wraps at every character
    run_phase(16'd0, 16'd0, 5'd1, 16'd0, PHASE_ITEMS);
    run_phase(16'd300, 16'd100, 5'd1, 16'd320, PHASE_ITEMS);
    repeat (4)
      run_phase(16'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                5'($urandom_range(1, 16)), 16'($urandom_range(64, 1500)), PHASE_ITEMS);
    settle();
    gaps_on = 1'b0;
    run_phase(16'd0, 16'd0, 5'd3, 16'd640, 200);

    settle();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (glyphs_due.size() != 0) begin
      errors++;
      $display("%0t: %0d glyphs expected but never placed", $time, glyphs_due.size());
    end
    $display("run took %0d text bytes over %0d register settings", bytes_taken, setups_run);
    $display("placed %0d glyphs, %0d of them multi-byte", glyphs_seen, wide_seen);
    if (errors == 0)
      $display("utf8_text_cursor_layout: match");
    else
      $display("utf8_text_cursor_layout: mismatch");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/utcl_pkg.sv
sv/utcl_if.sv
sv/utcl_decode.sv
sv/utcl_cursor.sv
sv/utf8_text_cursor_layout.sv
sim/utf8_text_cursor_layout_tb.sv
